### rtl/tcbd_pkg.sv
// Package for the capacitive touch baseline detector.
// Holds field widths, register codes, reset values and the configuration struct.
// No dependencies; every other file of the block but tcbd_ram imports it.
package tcbd_pkg;

    // Parameter defaults
    localparam int NUM_CHANNELS_DEF  = 5;
    localparam int SAMPLE_BITS_DEF   = 12;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed field widths
    localparam int CH_W       = 3;
    localparam int STRENGTH_W = 13;
    localparam int OFFSET_W   = 8;
    localparam int COUNT_W    = 8;
    localparam int ALPHA_W    = 9;
    localparam int ALPHA_FRAC = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 2'd3;

    // Register reset values
    localparam logic [STRENGTH_W-1:0] THRESHOLD_RST = 13'd30;
    localparam logic [OFFSET_W-1:0]   OFFSET_RST    = 8'd5;
    localparam logic [COUNT_W-1:0]    CAL_COUNT_RST = 8'd100;
    localparam logic [ALPHA_W-1:0]    ALPHA_RST     = 9'd13;

    // Full-weight alpha (1.0 in Q1.8) and saturated count
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 9'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [STRENGTH_W-1:0] threshold;
        logic [OFFSET_W-1:0]   offset;
        logic [COUNT_W-1:0]    cal_count;
        logic [ALPHA_W-1:0]    alpha;
    } cfg_t;

endpackage

### rtl/tcbd_in_if.sv
// Sample channel interface: valid/ready plus channel index and raw sample.
// Depends on tcbd_pkg for the channel width and the sample width default.
interface tcbd_in_if #(
    parameter int SAMPLE_BITS = tcbd_pkg::SAMPLE_BITS_DEF
);
    import tcbd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

### rtl/tcbd_out_if.sv
// Result channel interface: valid/ready plus one result word.
// Depends on tcbd_pkg for the field widths.
interface tcbd_out_if;
    import tcbd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CH_W-1:0]       out_channel;
    logic                  calibrated;
    logic [STRENGTH_W-1:0] strength;
    logic                  touched;
    logic                  any_touched;

    modport source (output valid, output out_channel, output calibrated, output strength,
                    output touched, output any_touched, input ready);
    modport sink   (input valid, input out_channel, input calibrated, input strength,
                    input touched, input any_touched, output ready);
endinterface

### rtl/tcbd_cfg_if.sv
// Configuration write channel: valid/ready plus register index and data.
// Depends on tcbd_pkg for the index and data widths.
interface tcbd_cfg_if;
    import tcbd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tcbd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/tcbd_cfg_regs.sv
// Configuration register file: threshold, baseline offset, calibration count, alpha.
// Depends on tcbd_pkg and tcbd_cfg_if.
module tcbd_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    tcbd_cfg_if.sink      cfg,
    output tcbd_pkg::cfg_t regs
);
    import tcbd_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;
    logic wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;

    // Decode the write word into the addressed register
    always_comb
    begin
        regs_next = regs_reg;
        if (wr)
        begin
            unique case (cfg.index)
                REG_THRESHOLD: regs_next.threshold = cfg.data[STRENGTH_W-1:0];
                REG_OFFSET:    regs_next.offset    = cfg.data[OFFSET_W-1:0];
                REG_CAL_COUNT: regs_next.cal_count = cfg.data[COUNT_W-1:0];
                REG_ALPHA:     regs_next.alpha     = cfg.data[ALPHA_W-1:0];
                default:       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.threshold <= THRESHOLD_RST;
            regs_reg.offset    <= OFFSET_RST;
            regs_reg.cal_count <= CAL_COUNT_RST;
            regs_reg.alpha     <= ALPHA_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;
endmodule

### rtl/tcbd_update.sv
// Per-channel state update: low-pass filter step, sample count, baseline latch, strength.
// State word layout is {calibrated, count, baseline, filter}. Depends on tcbd_pkg.
module tcbd_update #(
    parameter int SAMPLE_BITS   = tcbd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = tcbd_pkg::FRACTION_BITS_DEF,
    parameter int FILT_W        = SAMPLE_BITS + FRACTION_BITS,
    parameter int STATE_W       = FILT_W + tcbd_pkg::STRENGTH_W + tcbd_pkg::COUNT_W + 1
) (
    input  tcbd_pkg::cfg_t                    regs,
    input  logic [SAMPLE_BITS-1:0]            sample,
    input  logic [STATE_W-1:0]                state_cur,
    output logic [STATE_W-1:0]                state_new,
    output logic                              strength_upd,
    output logic [tcbd_pkg::STRENGTH_W-1:0]   strength
);
    import tcbd_pkg::*;

    localparam int PROD_W = FILT_W + ALPHA_W;
    localparam int STEP_W = PROD_W - ALPHA_FRAC;
    localparam int CMP_W  = (SAMPLE_BITS > STRENGTH_W) ? SAMPLE_BITS : STRENGTH_W;

    typedef struct packed {
        logic                  cal;
        logic [COUNT_W-1:0]    count;
        logic [STRENGTH_W-1:0] baseline;
        logic [FILT_W-1:0]     filt;
    } chan_state_t;

    chan_state_t cur;
    chan_state_t nxt;

    logic [ALPHA_W-1:0]     alpha_sat;
    logic [FILT_W-1:0]      target;
    logic                   rising;
    logic [FILT_W-1:0]      diff;
    logic [PROD_W-1:0]      prod;
    logic [PROD_W-1:0]      prod_up;
    logic [STEP_W-1:0]      step;
    logic [FILT_W-1:0]      filt_step;
    logic [CMP_W-1:0]       fint;
    logic [CMP_W-1:0]       base_ext;
    logic [CMP_W-1:0]       gap;
    logic [CMP_W:0]         base_sum;
    logic [COUNT_W-1:0]     need;

    assign cur = chan_state_t'(state_cur);

    // Filter step: rise rounds down, fall rounds the decrement up
    always_comb
    begin
        alpha_sat = (regs.alpha > ALPHA_MAX) ? ALPHA_MAX : regs.alpha;
        target    = {sample, {FRACTION_BITS{1'b0}}};
        rising    = (target >= cur.filt);
        diff      = rising ? (target - cur.filt) : (cur.filt - target);
        prod      = PROD_W'(alpha_sat) * PROD_W'(diff);
        prod_up   = prod + PROD_W'({ALPHA_FRAC{1'b1}});
        step      = rising ? prod[PROD_W-1:ALPHA_FRAC] : prod_up[PROD_W-1:ALPHA_FRAC];
        filt_step = rising ? (cur.filt + FILT_W'(step)) : (cur.filt - FILT_W'(step));
    end

    // Count, baseline latch and strength
    always_comb
    begin
        nxt          = cur;
        nxt.filt     = (cur.count == '0) ? target : filt_step;
        nxt.count    = (cur.count == COUNT_MAX) ? cur.count : cur.count + 1'b1;
        need         = (regs.cal_count == '0) ? COUNT_W'(1) : regs.cal_count;
        fint         = CMP_W'(nxt.filt[FILT_W-1:FRACTION_BITS]);
        base_ext     = CMP_W'(cur.baseline);
        gap          = (base_ext > fint) ? (base_ext - fint) : '0;
        base_sum     = (CMP_W+1)'(fint) + (CMP_W+1)'(regs.offset);
        strength_upd = cur.cal;
        strength     = '0;
        if (cur.cal)
        begin
            strength = gap[STRENGTH_W-1:0];
        end
        else if (nxt.count >= need)
        begin
            nxt.baseline = base_sum[STRENGTH_W-1:0];
            nxt.cal      = 1'b1;
        end
    end

    assign state_new = STATE_W'(nxt);
endmodule

### rtl/capacitive_touch_baseline_detector_core.sv
// Capacitive touch baseline detector, several pads on one sample stream.
// Word flow: an accepted word is held in stage 1, then in the output register.
// Throughput: one word per cycle if the output does not stall; channel state is
// read-modify-written in one RAM (read at accept, written from stage 1) with a bypass of the last write.
// Reset: registers return to defaults and per-channel valid bits clear, so every
// channel's state reads as zero; no clearing pass, samples are taken at once.
module capacitive_touch_baseline_detector_core #(
    parameter int NUM_CHANNELS  = tcbd_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS   = tcbd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = tcbd_pkg::FRACTION_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tcbd_in_if.sink    samples,
    tcbd_out_if.source results,
    tcbd_cfg_if.sink   cfg
);
    import tcbd_pkg::*;

    localparam int FILT_W  = SAMPLE_BITS + FRACTION_BITS;
    localparam int STATE_W = FILT_W + STRENGTH_W + COUNT_W + 1;
    localparam int ADDR_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    cfg_t regs;

    // Handshake
    logic accept;
    logic in_range;
    logic out_free;
    logic s1_fire;

    // Stage 1 (RAM data available)
    logic                   s1_valid_reg;
    logic [CH_W-1:0]        s1_channel_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_in_range_reg;
    logic                   s1_vld_reg;
    logic                   s1_vld_next;
    logic [ADDR_W-1:0]      s1_addr;

    // Last write, for the bypass
    logic                   wr_valid_reg;
    logic [ADDR_W-1:0]      wr_addr_reg;
    logic [STATE_W-1:0]     wr_data_reg;

    // State datapath
    logic [NUM_CHANNELS-1:0] vld_reg;
    logic [STATE_W-1:0]      ram_rdata;
    logic [STATE_W-1:0]      state_cur;
    logic [STATE_W-1:0]      state_new;
    logic                    strength_upd;
    logic [STRENGTH_W-1:0]   strength_calc;
    logic                    we;
    logic                    cal_new;

    logic [STRENGTH_W-1:0]   last_strength_reg [NUM_CHANNELS];
    logic                    any_next;
    logic [STRENGTH_W-1:0]   strength_next;

    // Output register
    logic                  out_valid_reg;
    logic [CH_W-1:0]       out_channel_reg;
    logic                  out_cal_reg;
    logic [STRENGTH_W-1:0] out_strength_reg;
    logic                  out_touched_reg;
    logic                  out_any_reg;

    tcbd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Accept a word whenever stage 1 is empty or moves on
    assign out_free      = !out_valid_reg || results.ready;
    assign s1_fire       = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;
    assign accept        = samples.valid && samples.ready;
    assign in_range      = (int'(samples.channel) < NUM_CHANNELS);
    assign s1_addr       = ADDR_W'(s1_channel_reg);
    assign we            = s1_fire && s1_in_range_reg;

    // Sample the valid bit of the addressed channel at read time
    always_comb
    begin
        s1_vld_next = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (ADDR_W'(samples.channel) == ADDR_W'(i))
            begin
                s1_vld_next = vld_reg[i];
            end
        end
        if (!in_range)
        begin
            s1_vld_next = 1'b0;
        end
    end

    tcbd_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (we),
        .waddr (s1_addr),
        .wdata (state_new),
        .re    (accept && in_range),
        .raddr (ADDR_W'(samples.channel)),
        .rdata (ram_rdata)
    );

    // Bypass the write that landed at the read edge; never-written reads zero
    always_comb
    begin
        if (wr_valid_reg && wr_addr_reg == s1_addr)
        begin
            state_cur = wr_data_reg;
        end
        else if (s1_vld_reg)
        begin
            state_cur = ram_rdata;
        end
        else
        begin
            state_cur = '0;
        end
    end

    tcbd_update #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_update (
        .regs         (regs),
        .sample       (s1_sample_reg),
        .state_cur    (state_cur),
        .state_new    (state_new),
        .strength_upd (strength_upd),
        .strength     (strength_calc)
    );

    assign cal_new = state_new[STATE_W-1];

    // Result fields and the any-pad flag over the updated strengths
    always_comb
    begin
        strength_next = (s1_in_range_reg && strength_upd) ? strength_calc : '0;
        any_next      = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (s1_in_range_reg && strength_upd && s1_addr == ADDR_W'(i))
            begin
                any_next = any_next || (strength_calc > regs.threshold);
            end
            else
            begin
                any_next = any_next || (last_strength_reg[i] > regs.threshold);
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= accept;
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_channel_reg  <= samples.channel;
            s1_sample_reg   <= samples.sample;
            s1_in_range_reg <= in_range;
            s1_vld_reg      <= s1_vld_next;
        end
    end

    // Track the last write and the per-channel valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
            vld_reg      <= '0;
        end
        else if (we)
        begin
            wr_valid_reg <= 1'b1;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (s1_addr == ADDR_W'(i))
                begin
                    vld_reg[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            wr_addr_reg <= s1_addr;
            wr_data_reg <= state_new;
        end
    end

    // Hold each channel's last strength
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                last_strength_reg[i] <= '0;
            end
        end
        else if (we && strength_upd)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (s1_addr == ADDR_W'(i))
                begin
                    last_strength_reg[i] <= strength_calc;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_channel_reg  <= s1_channel_reg;
            out_cal_reg      <= s1_in_range_reg && cal_new;
            out_strength_reg <= strength_next;
            out_touched_reg  <= (strength_next > regs.threshold);
            out_any_reg      <= any_next;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_channel_reg;
    assign results.calibrated  = out_cal_reg;
    assign results.strength    = out_strength_reg;
    assign results.touched     = out_touched_reg;
    assign results.any_touched = out_any_reg;
endmodule
